// File: design/utf8pv_pkg.sv
// Package with error codes, constants and the code point check of the UTF-8 validator.
package utf8pv_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POINT_W = 21;
    localparam int unsigned OWED_W  = 2;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 32;

    localparam logic [POINT_W-1:0] POINT_MAX     = 21'h10FFFF;
    localparam logic [POINT_W-1:0] SURR_LO       = 21'h00D800;
    localparam logic [POINT_W-1:0] SURR_HI       = 21'h00DFFF;
    localparam logic [POINT_W-1:0] MIN_LEN2      = 21'h000080;
    localparam logic [POINT_W-1:0] MIN_LEN3      = 21'h000800;
    localparam logic [POINT_W-1:0] MIN_LEN4      = 21'h010000;
    localparam logic [POINT_W-1:0] CP_TAB        = 21'h000009;
    localparam logic [POINT_W-1:0] CP_LF         = 21'h00000A;
    localparam logic [POINT_W-1:0] CP_CR         = 21'h00000D;
    localparam logic [POINT_W-1:0] CP_SPACE      = 21'h000020;
    localparam logic [POINT_W-1:0] CP_DEL        = 21'h00007F;
    localparam logic [POINT_W-1:0] C1_LO         = 21'h000080;
    localparam logic [POINT_W-1:0] C1_HI         = 21'h00009F;

    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    // Sticky error codes, first wins; a cut-off end turns ERR_CONT into ERR_TRUNC.
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_LEAD     = 3'd1,
        ERR_CONT     = 3'd2,
        ERR_OVERLONG = 3'd3,
        ERR_RANGE    = 3'd4,
        ERR_CONTROL  = 3'd5,
        ERR_TRUNC    = 3'd6
    } err_t;

    // Checks a finished code point: overlong first, then range, then control.
    function automatic err_t judge_point(input logic [POINT_W-1:0] p,
                                         input logic [LEN_W-1:0]   len);
        logic overlong;
        logic out_range;
        logic showable;
        overlong  = ((len == LEN_TWO)   && (p < MIN_LEN2)) ||
                    ((len == LEN_THREE) && (p < MIN_LEN3)) ||
                    ((len == LEN_FOUR)  && (p < MIN_LEN4));
        out_range = (p > POINT_MAX) || ((p >= SURR_LO) && (p <= SURR_HI));
        showable  = (p == CP_TAB) || (p == CP_LF) || (p == CP_CR) ||
                    !((p < CP_SPACE) || (p == CP_DEL) || ((p >= C1_LO) && (p <= C1_HI)));
        if (overlong) begin
            return ERR_OVERLONG;
        end else if (out_range) begin
            return ERR_RANGE;
        end else if (!showable) begin
            return ERR_CONTROL;
        end
        return ERR_NONE;
    endfunction

endpackage

// File: design/utf8_printable_validator.sv
// Top level of the streaming UTF-8 validator with a showable code point check.
//
// Usage:
// The slave channel takes one message byte per request: s_tdata holds the byte,
// s_tlast marks the final byte of a message. The master channel gives exactly one
// result per byte. m_tuser flags that a well-formed, showable code point ended at
// this byte; m_tdata carries that point (zero otherwise), the sticky first error
// code and, on the final byte, the message verdict; m_tlast marks the result of the
// final byte. After the final byte the decoder state returns to its reset values.
// Pipeline: an accepted byte is held in the input register, and its result is
// registered in the result register when that register can advance.
// Throughput: one byte per cycle while the receiver does not stall; the whole decode
// step is one short combinational pass from the input register to the result register.
// Reset (aresetn low, synchronous) empties both registers and clears the decoder.
// When the receiver stalls, the result register holds; the input register still
// takes one more byte, and s_tready falls only once both registers are full.
module utf8_printable_validator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [utf8pv_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic                          s_tlast,     // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [utf8pv_pkg::M_TDATA_W-1:0] m_tdata,  // [20:0] code_point, [23:21]
                                                       // error_code, [24] message_ok,
                                                       // [31:25] zero
    output logic                          m_tuser,     // point_ready
    output logic                          m_tlast      // message_done
);
    import utf8pv_pkg::*;

    // Input register
    logic                  in_valid_reg;
    logic [BYTE_W-1:0]     in_byte_reg;
    logic                  in_last_reg;

    // Decoder state
    logic [OWED_W-1:0]     owed_reg, owed_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [POINT_W-1:0]    partial_reg, partial_next;
    err_t                  err_reg, err_next;

    // Result register
    logic                  out_valid_reg;
    logic                  out_ready_reg, out_ready_next;
    logic [POINT_W-1:0]    out_cp_reg, out_cp_next;
    err_t                  out_err_reg;
    logic                  out_done_reg;
    logic                  out_ok_reg, out_ok_next;

    logic                  advance;
    logic                  complete;
    err_t                  judged;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // One decode step for the byte in the input register.
    always_comb begin
        owed_next      = owed_reg;
        len_next       = len_reg;
        partial_next   = partial_reg;
        err_next       = err_reg;
        complete       = 1'b0;
        out_ready_next = 1'b0;
        out_cp_next    = '0;
        judged         = ERR_NONE;

        if (err_reg != ERR_NONE) begin
            // After an error only a broken sequence keeps counting its bytes.
            if ((err_reg == ERR_CONT) && (owed_reg != '0)) begin
                owed_next = owed_reg - 1'b1;
            end
        end else if (owed_reg == '0) begin
            // Lead byte position.
            if (in_byte_reg[7] == 1'b0) begin
                partial_next = {{(POINT_W-BYTE_W){1'b0}}, in_byte_reg};
                len_next     = LEN_ONE;
                complete     = 1'b1;
            end else if (in_byte_reg[7:5] == 3'b110) begin
                partial_next = {{(POINT_W-5){1'b0}}, in_byte_reg[4:0]};
                len_next     = LEN_TWO;
                owed_next    = 2'd1;
            end else if (in_byte_reg[7:4] == 4'b1110) begin
                partial_next = {{(POINT_W-4){1'b0}}, in_byte_reg[3:0]};
                len_next     = LEN_THREE;
                owed_next    = 2'd2;
            end else if (in_byte_reg[7:3] == 5'b11110) begin
                partial_next = {{(POINT_W-3){1'b0}}, in_byte_reg[2:0]};
                len_next     = LEN_FOUR;
                owed_next    = 2'd3;
            end else begin
                err_next = ERR_LEAD;
            end
        end else begin
            // Continuation byte position.
            owed_next = owed_reg - 1'b1;
            if (in_byte_reg[7:6] != 2'b10) begin
                err_next = ERR_CONT;
            end else begin
                partial_next = {partial_reg[POINT_W-7:0], in_byte_reg[5:0]};
                complete     = (owed_next == '0);
            end
        end

        // Judge a finished point and clear the sequence.
        if (complete) begin
            judged = judge_point(partial_next, len_next);
            if (judged != ERR_NONE) begin
                err_next = judged;
            end else begin
                out_ready_next = 1'b1;
                out_cp_next    = partial_next;
            end
            owed_next    = '0;
            len_next     = '0;
            partial_next = '0;
        end

        // A sequence cut off by the message end.
        if (in_last_reg && (owed_next != '0) &&
            ((err_next == ERR_NONE) || (err_next == ERR_CONT))) begin
            err_next = ERR_TRUNC;
        end

        out_ok_next = in_last_reg && (err_next == ERR_NONE);
    end

    // Input register and its valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready) begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    // Decoder state, updated when a byte moves into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owed_reg    <= '0;
            len_reg     <= '0;
            partial_reg <= '0;
            err_reg     <= ERR_NONE;
        end else if (advance && in_valid_reg) begin
            if (in_last_reg) begin
                owed_reg    <= '0;
                len_reg     <= '0;
                partial_reg <= '0;
                err_reg     <= ERR_NONE;
            end else begin
                owed_reg    <= owed_next;
                len_reg     <= len_next;
                partial_reg <= partial_next;
                err_reg     <= err_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            out_ready_reg <= out_ready_next;
            out_cp_reg    <= out_cp_next;
            out_err_reg   <= err_next;
            out_done_reg  <= in_last_reg;
            out_ok_reg    <= out_ok_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-POINT_W-4){1'b0}}, out_ok_reg, out_err_reg, out_cp_reg};
    assign m_tuser  = out_ready_reg;
    assign m_tlast  = out_done_reg;

endmodule
